>>> design/oas_pkg.sv
// Shared types, register codes and reset values for the obstacle avoid steering block.
package oas_pkg;

    localparam int DIST_W  = 10;
    localparam int SPEED_W = 10;
    localparam int GAIN_W  = 6;
    localparam int DB_W    = 4;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 10;

    localparam int FIFO_DEPTH = 2;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [SPEED_W-1:0] WHEEL_MAX  = 10'd1000;
    localparam logic [DIST_W-1:0]  FILT_RESET = 10'd400;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_FRONT_SAFE  = 3'd0;
    localparam logic [CIDX_W-1:0] REG_SIDE_EMERG  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_BASE_SPEED  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_SPIN_SPEED  = 3'd3;
    localparam logic [CIDX_W-1:0] REG_STEER_GAIN  = 3'd4;
    localparam logic [CIDX_W-1:0] REG_MAX_OFFSET  = 3'd5;
    localparam logic [CIDX_W-1:0] REG_DEAD_BAND   = 3'd6;
    localparam logic [CIDX_W-1:0] REG_SENSOR_MAX  = 3'd7;

    typedef enum logic [1:0] {
        MOTION_FWD        = 2'd0,
        MOTION_SPIN_LEFT  = 2'd1,
        MOTION_SPIN_RIGHT = 2'd2
    } motion_t;

    typedef struct packed {
        logic [DIST_W-1:0]  front_clear_min;
        logic [DIST_W-1:0]  side_clear_min;
        logic [SPEED_W-1:0] base_speed;
        logic [SPEED_W-1:0] spin_speed;
        logic [GAIN_W-1:0]  steer_gain;
        logic [SPEED_W-1:0] offset_limit;
        logic [DB_W-1:0]    dead_band;
        logic [DIST_W-1:0]  range_max;
    } cfg_t;

    typedef struct packed {
        logic [DIST_W-1:0] left;
        logic [DIST_W-1:0] center;
        logic [DIST_W-1:0] right;
    } filt_t;

endpackage

>>> design/obstacle_avoid_steering.sv
// A word passes the queue, stage-1 registers and output register before out_valid.
// Throughput: one word per cycle while out_ready holds; kept values update per word.
// Front filters into a two-entry queue; the back end is a two-stage pipeline
// (steering product, then clamps into the output register).
// Reset: config registers take their defaults, kept distances go to 400,
// queue and pipeline empty.
module obstacle_avoid_steering
    import oas_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [DIST_W-1:0]  raw_left,
    input  logic [DIST_W-1:0]  raw_center,
    input  logic [DIST_W-1:0]  raw_right,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         motion,
    output logic [SPEED_W-1:0] left_speed,
    output logic [SPEED_W-1:0] right_speed,
    output logic [DIST_W-1:0]  filt_left,
    output logic [DIST_W-1:0]  filt_center,
    output logic [DIST_W-1:0]  filt_right
);

    cfg_t  cfg_reg;
    logic  q_full;
    logic  q_push;
    filt_t q_in;
    logic  q_pop;
    filt_t q_out;
    logic  q_not_empty;
    logic  back_ready;
    filt_t out_filt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.front_clear_min <= 10'd25;
            cfg_reg.side_clear_min  <= 10'd7;
            cfg_reg.base_speed      <= 10'd450;
            cfg_reg.spin_speed      <= 10'd450;
            cfg_reg.steer_gain      <= 6'd15;
            cfg_reg.offset_limit    <= 10'd200;
            cfg_reg.dead_band       <= 4'd2;
            cfg_reg.range_max       <= 10'd400;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRONT_SAFE: cfg_reg.front_clear_min <= cfg_data;
                REG_SIDE_EMERG: cfg_reg.side_clear_min  <= cfg_data;
                REG_BASE_SPEED: cfg_reg.base_speed      <= cfg_data;
                REG_SPIN_SPEED: cfg_reg.spin_speed      <= cfg_data;
                REG_STEER_GAIN: cfg_reg.steer_gain      <= cfg_data[GAIN_W-1:0];
                REG_MAX_OFFSET: cfg_reg.offset_limit    <= cfg_data;
                REG_DEAD_BAND:  cfg_reg.dead_band       <= cfg_data[DB_W-1:0];
                REG_SENSOR_MAX: cfg_reg.range_max       <= cfg_data;
                default:        ;
            endcase
        end
    end

    oas_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .raw_left   (raw_left),
        .raw_center (raw_center),
        .raw_right  (raw_right),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_in)
    );

    oas_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .not_empty (q_not_empty)
    );

    assign q_pop = q_not_empty && back_ready;

    oas_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (q_not_empty),
        .in_ready    (back_ready),
        .in_data     (q_out),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .motion      (motion),
        .left_speed  (left_speed),
        .right_speed (right_speed),
        .out_filt    (out_filt)
    );

    assign filt_left   = out_filt.left;
    assign filt_center = out_filt.center;
    assign filt_right  = out_filt.right;

`ifndef SYNTH
    // spins drive both wheels at the same speed
    a_spin_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && motion != MOTION_FWD) |-> (left_speed == right_speed))
        else $error("spin with unequal wheel speeds");

    a_speed_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_speed <= WHEEL_MAX && right_speed <= WHEEL_MAX))
        else $error("wheel speed above limit");

    // kept distances start nonzero and only take nonzero values
    a_filt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (filt_left != '0 && filt_center != '0 && filt_right != '0))
        else $error("filtered distance is zero");

    a_motion_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (motion == MOTION_FWD || motion == MOTION_SPIN_LEFT ||
                       motion == MOTION_SPIN_RIGHT))
        else $error("bad motion code");
`endif

endmodule

>>> design/oas_front.sv
// Front end: per-sensor distance filter and kept values.
module oas_front
    import oas_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  in_valid,
    output logic  in_ready,
    input  logic [DIST_W-1:0] raw_left,
    input  logic [DIST_W-1:0] raw_center,
    input  logic [DIST_W-1:0] raw_right,
    input  logic  q_full,
    output logic  q_push,
    output filt_t q_data
);

    filt_t kept_reg;
    filt_t kept_next;

    function automatic logic [DIST_W-1:0] smooth(
        input logic [DIST_W-1:0] kept,
        input logic [DIST_W-1:0] raw,
        input logic [DIST_W-1:0] smax
    );
        logic [DIST_W-1:0] delta;
        logic [13:0]       kept3;
        logic [13:0]       delta10;
        logic [DIST_W:0]   sum;
        begin
            delta   = (raw > kept) ? (raw - kept) : (kept - raw);
            kept3   = 14'(kept) * 14'd3;
            delta10 = 14'(delta) * 14'd10;
            sum     = {1'b0, kept} + {1'b0, raw};
            if (raw == '0 || raw > smax)
                smooth = kept;
            else if (kept == '0)
                smooth = raw;
            // delta > floor(3k/10) is the same as 3k < 10*delta
            else if (kept3 < delta10)
                smooth = raw;
            else
                smooth = sum[DIST_W:1];
        end
    endfunction

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    always_comb
    begin
        kept_next.left   = smooth(kept_reg.left,   raw_left,   cfg.range_max);
        kept_next.center = smooth(kept_reg.center, raw_center, cfg.range_max);
        kept_next.right  = smooth(kept_reg.right,  raw_right,  cfg.range_max);
    end

    assign q_data = kept_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_reg.left   <= FILT_RESET;
            kept_reg.center <= FILT_RESET;
            kept_reg.right  <= FILT_RESET;
        end
        else if (q_push)
        begin
            kept_reg <= kept_next;
        end
    end

endmodule

>>> design/oas_fifo.sv
// Short queue of filtered words between front and back.
module oas_fifo
    import oas_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  filt_t push_data,
    output logic  full,
    input  logic  pop,
    output filt_t pop_data,
    output logic  not_empty
);

    filt_t              mem_reg [FIFO_DEPTH];
    logic [FPTR_W-1:0]  wr_ptr_reg;
    logic [FPTR_W-1:0]  rd_ptr_reg;
    logic [FCNT_W-1:0]  count_reg;
    logic [FCNT_W-1:0]  count_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == FCNT_W'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

endmodule

>>> design/oas_back.sv
// Back end: drive decision, steering product, wheel clamps and output register.
module oas_back
    import oas_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  in_valid,
    output logic  in_ready,
    input  filt_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output logic [1:0]         motion,
    output logic [SPEED_W-1:0] left_speed,
    output logic [SPEED_W-1:0] right_speed,
    output filt_t out_filt
);

    // stage 1: decision and product
    logic               s1_valid_reg;
    filt_t              s1_filt_reg;
    motion_t            s1_motion_reg;
    logic signed [17:0] s1_prod_reg;

    motion_t            motion_d;
    logic signed [10:0] diff;
    logic signed [10:0] db_s;
    logic signed [10:0] diff_db;
    logic signed [17:0] prod;

    // stage 2: output register
    logic               out_valid_reg;
    motion_t            motion_reg;
    logic [SPEED_W-1:0] left_reg;
    logic [SPEED_W-1:0] right_reg;
    filt_t              filt_reg;

    logic               adv_out;
    logic signed [17:0] lim;
    logic signed [17:0] off;
    logic signed [11:0] off12;
    logic signed [11:0] base12;
    logic signed [11:0] wmax12;
    logic signed [11:0] ls_s;
    logic signed [11:0] rs_s;
    logic [SPEED_W-1:0] ls_next;
    logic [SPEED_W-1:0] rs_next;
    logic [SPEED_W-1:0] spin;

    assign adv_out  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || adv_out;

    always_comb
    begin
        if (in_data.center < cfg.front_clear_min)
            motion_d = (in_data.left >= in_data.right) ? MOTION_SPIN_LEFT : MOTION_SPIN_RIGHT;
        else if (in_data.left < cfg.side_clear_min)
            motion_d = MOTION_SPIN_RIGHT;
        else if (in_data.right < cfg.side_clear_min)
            motion_d = MOTION_SPIN_LEFT;
        else
            motion_d = MOTION_FWD;

        diff    = $signed({1'b0, in_data.left}) - $signed({1'b0, in_data.right});
        db_s    = $signed({7'b0, cfg.dead_band});
        diff_db = (diff >= -db_s && diff <= db_s) ? 11'sd0 : diff;
        prod    = diff_db * $signed({1'b0, cfg.steer_gain});
    end

    always_comb
    begin
        lim    = $signed({8'b0, cfg.offset_limit});
        if (s1_prod_reg > lim)
            off = lim;
        else if (s1_prod_reg < -lim)
            off = -lim;
        else
            off = s1_prod_reg;
        off12  = off[11:0];
        base12 = $signed({2'b0, cfg.base_speed});
        wmax12 = $signed({2'b0, WHEEL_MAX});
        ls_s   = base12 - off12;
        rs_s   = base12 + off12;

        if (ls_s < 12'sd0)
            ls_next = '0;
        else if (ls_s > wmax12)
            ls_next = WHEEL_MAX;
        else
            ls_next = ls_s[SPEED_W-1:0];

        if (rs_s < 12'sd0)
            rs_next = '0;
        else if (rs_s > wmax12)
            rs_next = WHEEL_MAX;
        else
            rs_next = rs_s[SPEED_W-1:0];

        spin = (cfg.spin_speed > WHEEL_MAX) ? WHEEL_MAX : cfg.spin_speed;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            s1_filt_reg   <= in_data;
            s1_motion_reg <= motion_d;
            s1_prod_reg   <= prod;
        end
        if (adv_out)
        begin
            motion_reg <= s1_motion_reg;
            filt_reg   <= s1_filt_reg;
            if (s1_motion_reg == MOTION_FWD)
            begin
                left_reg  <= ls_next;
                right_reg <= rs_next;
            end
            else
            begin
                left_reg  <= spin;
                right_reg <= spin;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (adv_out)
                out_valid_reg <= s1_valid_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign motion      = motion_reg;
    assign left_speed  = left_reg;
    assign right_speed = right_reg;
    assign out_filt    = filt_reg;

endmodule
